// ===== src/srfc8_pkg.sv =====
// ----------------------------------------------------------------------------
// SPI register frame CRC-8 check package
// Types, codes and the CRC-8 byte step shared by the frame pipeline.
// ----------------------------------------------------------------------------
package srfc8_pkg;

   localparam int unsigned MaxDataBytes = 4;
   localparam int unsigned ValueBytes   = 4;
   localparam int unsigned CountLimit   =
      (MaxDataBytes < ValueBytes) ? MaxDataBytes : ValueBytes;

   // Pipeline depth: capture, command CRC, four data bytes, read residue.
   localparam int unsigned NumStages = 7;
   localparam int unsigned DataStage = 2;

   localparam logic       OpWrite = 1'b0;
   localparam logic       OpRead  = 1'b1;
   localparam logic [7:0] CmdRead = 8'h40;

   localparam logic [1:0] ModeNone = 2'd0;
   localparam logic [1:0] ModeCrc  = 2'd1;
   localparam logic [1:0] ModeXor  = 2'd2;

   localparam logic CsrCheckMode  = 1'b0;
   localparam logic CsrPolynomial = 1'b1;

   localparam logic [7:0] PolyReset = 8'h07;

   typedef struct packed {
      logic        op;
      logic [7:0]  cmd;
      logic [2:0]  count;
      logic [31:0] data;   // frame data bytes, first one sent in the top byte
      logic [31:0] rval;   // assembled read value
      logic [7:0]  rc;
      logic [7:0]  crc;    // running CRC over command and data
      logic [7:0]  xs;     // running XOR over command, data and check byte
      logic [7:0]  res;    // CRC residue including the check byte
   } stage_type;

   // One byte of MSB-first CRC-8.
   function automatic logic [7:0] crc_byte(input logic [7:0] crc_i,
                                           input logic [7:0] data_i,
                                           input logic [7:0] poly_i);
      logic [7:0] c;
      logic       fb;
      c = crc_i;
      for (int b = 7; b >= 0; b--) begin
         fb = c[7] ^ data_i[b];
         c  = {c[6:0], 1'b0} ^ (fb ? poly_i : 8'h00);
      end
      return c;
   endfunction

endpackage

// ===== src/spi_register_frame_crc8_check_core.sv =====
// ----------------------------------------------------------------------------
// SPI register frame CRC-8 check core
// Builds register write and read frames and checks read responses.
// ----------------------------------------------------------------------------
// Usage: the request channel (req_*) takes one word per frame. A write word
// produces the command byte, the data bytes most significant first and, when
// checking is enabled, a CRC-8 byte. A read word produces a single read
// command byte that also carries the assembled read value and the check
// result. Each output byte is one word on the response channel (rsp_*), and
// rsp_last_byte marks the final byte of a frame.
// An accepted request passes through seven pipeline stages (capture, command
// CRC, four data byte CRC steps and the read residue step) and then the output
// serializer. Throughput is one response word per cycle while rsp_stall is
// low. A read request takes a single serializer word, a write request holds
// the serializer for its command, data and any CRC byte, and that serializer
// is what sets the request rate. When rsp_stall is high while the serializer
// holds a word, that word stays and the whole pipeline freezes, raising
// req_stall; no word is lost or repeated. Synchronous reset empties the
// pipeline and the serializer, sets the check mode to none and the polynomial
// to 0x07. Configuration is written through csr_* while the core is idle; the
// user must keep to this, as the core itself does not enforce it.
// ----------------------------------------------------------------------------
module spi_register_frame_crc8_check_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operation,
   input  logic [5:0]  req_reg_address,
   input  logic [2:0]  req_byte_count,
   input  logic [31:0] req_write_value,
   input  logic [31:0] req_response_data,
   input  logic [7:0]  req_response_check,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_last_byte,
   output logic [31:0] rsp_read_value,
   output logic        rsp_check_error,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [7:0]  csr_write_data
);

   // Configuration registers.
   logic [1:0] mode_ff;
   logic [7:0] poly_ff;

   // Pipeline stages; valid bits travel alongside.
   srfc8_pkg::stage_type pipe_ff [srfc8_pkg::NumStages];
   srfc8_pkg::stage_type pipe_in [srfc8_pkg::NumStages];
   logic [srfc8_pkg::NumStages-1:0] vld_ff;

   // Output serializer.
   logic        ser_valid_ff, ser_valid_in;
   logic [39:0] ser_shift_ff, ser_shift_in;
   logic [2:0]  ser_left_ff, ser_left_in;
   logic [7:0]  ser_crc_ff, ser_crc_in;
   logic        ser_has_crc_ff, ser_has_crc_in;
   logic [31:0] ser_rval_ff, ser_rval_in;
   logic        ser_err_ff, ser_err_in;

   logic advance;
   logic pop;

   logic [2:0] clamp_count;
   logic [5:0] align_sh;
   logic [31:0] data_sel;
   logic [31:0] rdata_al;

   srfc8_pkg::stage_type tail;
   logic       has_crc;
   logic       err;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= srfc8_pkg::ModeNone;
         poly_ff <= srfc8_pkg::PolyReset;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            srfc8_pkg::CsrCheckMode:  mode_ff <= csr_write_data[1:0];
            srfc8_pkg::CsrPolynomial: poly_ff <= csr_write_data;
            default:                  ;
         endcase
      end
   end

   // The pipeline moves as a whole whenever the serializer can take a frame.
   assign pop       = ser_valid_ff && !rsp_stall;
   assign advance   = !ser_valid_ff || (pop && ser_left_ff == 3'd1);
   assign req_stall = !advance;

   always_comb begin
      // Capture stage: command byte, clamped count and left-aligned data.
      if (req_byte_count == 3'd0) begin
         clamp_count = 3'd1;
      end else if (req_byte_count > 3'(srfc8_pkg::CountLimit)) begin
         clamp_count = 3'(srfc8_pkg::CountLimit);
      end else begin
         clamp_count = req_byte_count;
      end
      align_sh = {3'(3'(srfc8_pkg::ValueBytes) - clamp_count), 3'b000};
      data_sel = (req_operation == srfc8_pkg::OpRead) ? req_response_data
                                                      : req_write_value;
      rdata_al = req_response_data << align_sh;

      pipe_in[0].op    = req_operation;
      pipe_in[0].cmd   = {2'b00, req_reg_address} |
                         ((req_operation == srfc8_pkg::OpRead) ? srfc8_pkg::CmdRead
                                                               : 8'h00);
      pipe_in[0].count = clamp_count;
      pipe_in[0].data  = data_sel << align_sh;
      pipe_in[0].rval  = rdata_al >> align_sh;
      pipe_in[0].rc    = req_response_check;
      pipe_in[0].crc   = 8'h00;
      pipe_in[0].xs    = 8'h00;
      pipe_in[0].res   = 8'h00;

      // One CRC byte step per stage, skipped in data stages beyond the byte count.
      for (int i = 1; i < srfc8_pkg::NumStages; i++) begin
         pipe_in[i] = pipe_ff[i-1];
         if (i == 1) begin
            pipe_in[i].crc = srfc8_pkg::crc_byte(8'h00, pipe_ff[i-1].cmd, poly_ff);
            pipe_in[i].xs  = pipe_ff[i-1].cmd;
         end else if (i == srfc8_pkg::NumStages - 1) begin
            pipe_in[i].res = srfc8_pkg::crc_byte(pipe_ff[i-1].crc, pipe_ff[i-1].rc,
                                                 poly_ff);
            pipe_in[i].xs  = pipe_ff[i-1].xs ^ pipe_ff[i-1].rc;
         end else if (3'(i - srfc8_pkg::DataStage) < pipe_ff[i-1].count) begin
            pipe_in[i].crc = srfc8_pkg::crc_byte(
               pipe_ff[i-1].crc,
               pipe_ff[i-1].data[31 - 8 * (i - srfc8_pkg::DataStage) -: 8],
               poly_ff);
            pipe_in[i].xs  = pipe_ff[i-1].xs ^
                             pipe_ff[i-1].data[31 - 8 * (i - srfc8_pkg::DataStage) -: 8];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[srfc8_pkg::NumStages-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < srfc8_pkg::NumStages; i++) begin
            pipe_ff[i] <= pipe_in[i];
         end
      end
   end

   // Serializer load and shift.
   always_comb begin
      tail    = pipe_ff[srfc8_pkg::NumStages-1];
      has_crc = (tail.op == srfc8_pkg::OpWrite) &&
                (mode_ff == srfc8_pkg::ModeCrc || mode_ff == srfc8_pkg::ModeXor);
      err     = 1'b0;
      if (tail.op == srfc8_pkg::OpRead) begin
         if (mode_ff == srfc8_pkg::ModeCrc) begin
            err = tail.res != 8'h00;
         end else if (mode_ff == srfc8_pkg::ModeXor) begin
            err = tail.xs != 8'h00;
         end
      end

      ser_valid_in   = ser_valid_ff;
      ser_shift_in   = ser_shift_ff;
      ser_left_in    = ser_left_ff;
      ser_crc_in     = ser_crc_ff;
      ser_has_crc_in = ser_has_crc_ff;
      ser_rval_in    = ser_rval_ff;
      ser_err_in     = ser_err_ff;

      if (advance) begin
         ser_valid_in   = vld_ff[srfc8_pkg::NumStages-1];
         ser_shift_in   = {tail.cmd, tail.data};
         ser_crc_in     = tail.crc;
         ser_has_crc_in = has_crc;
         ser_err_in     = err;
         if (tail.op == srfc8_pkg::OpRead) begin
            ser_left_in = 3'd1;
            ser_rval_in = err ? 32'h0 : tail.rval;
         end else begin
            ser_left_in = 3'd1 + tail.count + {2'b00, has_crc};
            ser_rval_in = 32'h0;
         end
      end else if (pop) begin
         ser_shift_in = {ser_shift_ff[31:0], 8'h00};
         ser_left_in  = ser_left_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ser_valid_ff <= 1'b0;
      end else begin
         ser_valid_ff <= ser_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ser_shift_ff   <= ser_shift_in;
      ser_left_ff    <= ser_left_in;
      ser_crc_ff     <= ser_crc_in;
      ser_has_crc_ff <= ser_has_crc_in;
      ser_rval_ff    <= ser_rval_in;
      ser_err_ff     <= ser_err_in;
   end

   // The CRC byte goes out last, in place of the exhausted shift register.
   assign rsp_valid       = ser_valid_ff;
   assign rsp_last_byte   = ser_left_ff == 3'd1;
   assign rsp_tx_byte     = (ser_has_crc_ff && ser_left_ff == 3'd1) ? ser_crc_ff
                                                                    : ser_shift_ff[39:32];
   assign rsp_read_value  = ser_rval_ff;
   assign rsp_check_error = ser_err_ff;

endmodule
